[hdl/assert_macros.svh]
//==============================================================================
// Assertion macros
// Shared concurrent assertion helpers for the parser RTL.
//==============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/jsp_pkg.sv]
//==============================================================================
// jsp_pkg
// Types, constants and helper functions of the streaming JSON parser.
//==============================================================================
package jsp_pkg;

    localparam int MAX_NEST     = 64;
    localparam int ADDR_W       = $clog2(MAX_NEST);
    localparam int NEST_W       = ADDR_W + 1;
    localparam int LENGTH_WIDTH = 24;
    localparam int DLEN_W       = LENGTH_WIDTH + 1;
    localparam int OFFSET_WIDTH = 32;
    localparam int MAX_RES      = 4;
    localparam int QDEPTH       = 8;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic [5:0]              MAX_DEPTH_RESET = 6'd63;
    localparam logic [LENGTH_WIDTH-1:0] MAX_LEN_RESET   = LENGTH_WIDTH'(1048576);

    localparam logic CFG_MAX_DEPTH  = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        M_ROOT, M_ARR_FIRST, M_OBJ_FIRST, M_VALUE, M_KEY_EXPECT, M_COLON, M_AFTER,
        M_STR, M_STR_ESC, M_STR_HEX, M_KEY, M_KEY_ESC, M_KEY_HEX, M_LIT, M_NUM
    } mode_t;

    localparam logic [3:0] EV_OBJ_BEGIN = 4'd0;
    localparam logic [3:0] EV_OBJ_END   = 4'd1;
    localparam logic [3:0] EV_ARR_BEGIN = 4'd2;
    localparam logic [3:0] EV_ARR_END   = 4'd3;
    localparam logic [3:0] EV_KEY_BYTE  = 4'd4;
    localparam logic [3:0] EV_KEY_END   = 4'd5;
    localparam logic [3:0] EV_STR_BYTE  = 4'd6;
    localparam logic [3:0] EV_STR_END   = 4'd7;
    localparam logic [3:0] EV_NUM_BYTE  = 4'd8;
    localparam logic [3:0] EV_NUM_END   = 4'd9;
    localparam logic [3:0] EV_NULL      = 4'd10;
    localparam logic [3:0] EV_DONE      = 4'd13;
    localparam logic [3:0] EV_ERROR     = 4'd14;

    localparam logic [4:0] ERR_END_INPUT   = 5'd1;
    localparam logic [4:0] ERR_UNEXPECTED  = 5'd2;
    localparam logic [4:0] ERR_DEPTH       = 5'd3;
    localparam logic [4:0] ERR_LITERAL     = 5'd4;
    localparam logic [4:0] ERR_TRUNC_NUM   = 5'd5;
    localparam logic [4:0] ERR_NUMBER      = 5'd6;
    localparam logic [4:0] ERR_FRACTION    = 5'd7;
    localparam logic [4:0] ERR_EXPONENT    = 5'd8;
    localparam logic [4:0] ERR_EXP_STRING  = 5'd9;
    localparam logic [4:0] ERR_STR_LONG    = 5'd10;
    localparam logic [4:0] ERR_TRUNC_ESC   = 5'd11;
    localparam logic [4:0] ERR_TRUNC_UNI   = 5'd12;
    localparam logic [4:0] ERR_BAD_UNI     = 5'd13;
    localparam logic [4:0] ERR_BAD_ESC     = 5'd14;
    localparam logic [4:0] ERR_CTRL_CHAR   = 5'd15;
    localparam logic [4:0] ERR_UNTERM_STR  = 5'd16;
    localparam logic [4:0] ERR_UNTERM_ARR  = 5'd17;
    localparam logic [4:0] ERR_EXP_COMMA   = 5'd18;
    localparam logic [4:0] ERR_EXP_COLON   = 5'd19;
    localparam logic [4:0] ERR_UNTERM_OBJ  = 5'd20;
    localparam logic [4:0] ERR_TRAILING    = 5'd21;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  payload;
        logic        flt;
        logic [4:0]  code;
        logic [31:0] off;
        logic        last;
    } res_t;

    function automatic res_t mk_res(logic [3:0] kind, logic [7:0] payload, logic flt,
                                    logic [4:0] code, logic [31:0] off);
        res_t r;
        r.kind    = kind;
        r.payload = payload;
        r.flt     = flt;
        r.code    = code;
        r.off     = off;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [7:0] v;
        v = 8'd16;
        if (is_digit(c)) v = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
        return v[4:0];
    endfunction

    function automatic logic [2:0] lit_len(logic [1:0] kind);
        return (kind == 2'd2) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_char(logic [1:0] kind, logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case ({kind, idx})
            5'b00_000: ch = 8'h6E;
            5'b00_001: ch = 8'h75;
            5'b00_010: ch = 8'h6C;
            5'b00_011: ch = 8'h6C;
            5'b01_000: ch = 8'h74;
            5'b01_001: ch = 8'h72;
            5'b01_010: ch = 8'h75;
            5'b01_011: ch = 8'h65;
            5'b10_000: ch = 8'h66;
            5'b10_001: ch = 8'h61;
            5'b10_010: ch = 8'h6C;
            5'b10_011: ch = 8'h73;
            5'b10_100: ch = 8'h65;
            default:   ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[hdl/json_stream_parser.sv]
//==============================================================================
// json_stream_parser
// Streaming JSON validator and tokenizer, one document byte per cycle.
//==============================================================================
// Input transactions carry text_byte, byte_valid and end_of_text and are taken
// when in_valid is high and in_stall is low. Each one produces zero to four
// events, which leave through the output channel (out_valid, out_stall) one per
// cycle, with last_of_run marking the final event of an input transaction.
// An input transaction is processed in the cycle it is accepted, and its
// events are written into the registered event queue. The input side takes one
// transaction per cycle while the eight-entry event queue has room for four
// more events; in_stall depends only on the queue fill level, not on how many
// events a transaction produces. The container stack lives in a synchronous RAM
// whose entry below the top is read ahead every cycle; the top itself is kept
// in a register. Reset starts a new document with default limits and needs no
// clearing pass. When the receiver stalls, the queue fills and in_stall rises.
// Configuration writes through cfg_valid/cfg_ready are always accepted.
`include "assert_macros.svh"

module json_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        byte_valid,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_kind,
    output logic [7:0]  payload_byte,
    output logic        number_is_float,
    output logic [4:0]  error_code,
    output logic [31:0] error_offset,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int AW = jsp_pkg::ADDR_W;
    localparam int NW = jsp_pkg::NEST_W;
    localparam int DW = jsp_pkg::DLEN_W;
    localparam int OW = jsp_pkg::OFFSET_WIDTH;
    localparam int LW = jsp_pkg::LENGTH_WIDTH;

    logic [5:0]     max_depth_reg;
    logic [LW-1:0]  max_len_reg;

    jsp_pkg::mode_t mode_reg, mode_next;
    logic [NW-1:0]  level_reg, level_next;
    logic [DW-1:0]  dlen_reg, dlen_next;
    logic [15:0]    uacc_reg, uacc_next;
    logic [2:0]     hcnt_reg, hcnt_next;
    logic [4:0]     lit_reg, lit_next;
    logic [2:0]     nphase_reg, nphase_next;
    logic           fseen_reg, fseen_next;
    logic [OW-1:0]  boff_reg, boff_next;
    logic [OW-1:0]  tstart_reg, tstart_next;
    logic           err_reg, err_next;
    logic           top_reg, top_next;

    logic           stack_mem [jsp_pkg::MAX_NEST];
    logic           second_reg;
    logic [AW-1:0]  rd_addr;
    logic [NW-1:0]  level_d;
    logic           push_en;
    logic           push_obj;

    jsp_pkg::res_t [3:0] res_q;
    logic [2:0]     res_n;

    jsp_pkg::res_t  queue_reg [jsp_pkg::QDEPTH];
    logic [jsp_pkg::QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [jsp_pkg::QCNT_W-1:0] cnt_reg;

    logic in_accept, out_accept;

    logic [7:0]     c;
    logic [OW-1:0]  pos;
    logic           do_start, do_after, obj, key, bad;
    logic [1:0]     lkind;
    logic [2:0]     lidx, hcnt_inc;
    logic [4:0]     hv;
    logic [DW:0]    lsum;
    logic [1:0]     ladd;
    logic [3:0]     kind_b;

    function automatic void add_res(inout jsp_pkg::res_t [3:0] q, inout logic [2:0] n,
                                    input jsp_pkg::res_t r);
        if (n < 3'd4)
        begin
            q[n[1:0]] = r;
            n = n + 3'd1;
        end
    endfunction

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign cfg_ready  = 1'b1;
    assign in_stall   = cnt_reg > jsp_pkg::QCNT_W'(jsp_pkg::QDEPTH - jsp_pkg::MAX_RES);

    always_comb
    begin
        mode_next   = mode_reg;
        level_next  = level_reg;
        dlen_next   = dlen_reg;
        uacc_next   = uacc_reg;
        hcnt_next   = hcnt_reg;
        lit_next    = lit_reg;
        nphase_next = nphase_reg;
        fseen_next  = fseen_reg;
        boff_next   = boff_reg;
        tstart_next = tstart_reg;
        err_next    = err_reg;
        top_next    = top_reg;
        push_en     = 1'b0;
        push_obj    = 1'b0;
        res_q       = '0;
        res_n       = 3'd0;
        c           = text_byte;
        pos         = boff_reg;
        do_start    = 1'b0;
        do_after    = 1'b0;
        obj         = 1'b0;
        key         = 1'b0;
        bad         = 1'b0;
        lkind       = 2'd0;
        lidx        = 3'd0;
        hcnt_inc    = 3'd0;
        hv          = 5'd0;
        lsum        = '0;
        ladd        = 2'd0;
        kind_b      = jsp_pkg::EV_STR_BYTE;

        if (byte_valid && !err_reg)
        begin
            key = (mode_reg == jsp_pkg::M_KEY) || (mode_reg == jsp_pkg::M_KEY_ESC) ||
                  (mode_reg == jsp_pkg::M_KEY_HEX);
            kind_b = key ? jsp_pkg::EV_KEY_BYTE : jsp_pkg::EV_STR_BYTE;
            case (mode_reg)
                jsp_pkg::M_ARR_FIRST:
                begin
                    if (jsp_pkg::is_ws(c))
                    begin
                    end
                    else if (c == 8'h5D)
                    begin
                        level_next = level_reg - NW'(1);
                        top_next   = second_reg;
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ARR_END, 8'd0,
                                1'b0, 5'd0, 32'd0));
                        mode_next = jsp_pkg::M_AFTER;
                    end
                    else if (level_reg > NW'(max_depth_reg))
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_DEPTH, pos));
                        err_next = 1'b1;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                jsp_pkg::M_OBJ_FIRST, jsp_pkg::M_KEY_EXPECT:
                begin
                    if (jsp_pkg::is_ws(c))
                    begin
                    end
                    else if (c == 8'h7D && mode_reg == jsp_pkg::M_OBJ_FIRST)
                    begin
                        level_next = level_reg - NW'(1);
                        top_next   = second_reg;
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_OBJ_END, 8'd0,
                                1'b0, 5'd0, 32'd0));
                        mode_next = jsp_pkg::M_AFTER;
                    end
                    else if (c == 8'h22)
                    begin
                        dlen_next = '0;
                        mode_next = jsp_pkg::M_KEY;
                    end
                    else
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_EXP_STRING, pos));
                        err_next = 1'b1;
                    end
                end
                jsp_pkg::M_COLON:
                begin
                    if (jsp_pkg::is_ws(c))
                    begin
                    end
                    else if (c == 8'h3A)
                    begin
                        if (level_reg > NW'(max_depth_reg))
                        begin
                            add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                    1'b0, jsp_pkg::ERR_DEPTH, pos + OW'(1)));
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = jsp_pkg::M_VALUE;
                        end
                    end
                    else
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_EXP_COLON, pos));
                        err_next = 1'b1;
                    end
                end
                jsp_pkg::M_AFTER:
                begin
                    do_after = 1'b1;
                end
                jsp_pkg::M_STR, jsp_pkg::M_KEY:
                begin
                    if (c == 8'h22)
                    begin
                        if (dlen_reg > DW'(max_len_reg))
                        begin
                            add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                    1'b0, jsp_pkg::ERR_STR_LONG, pos + OW'(1)));
                            err_next = 1'b1;
                        end
                        else
                        begin
                            add_res(res_q, res_n, jsp_pkg::mk_res(key ? jsp_pkg::EV_KEY_END :
                                    jsp_pkg::EV_STR_END, 8'd0, 1'b0, 5'd0, 32'd0));
                            mode_next = key ? jsp_pkg::M_COLON : jsp_pkg::M_AFTER;
                        end
                    end
                    else if (c == 8'h5C)
                    begin
                        tstart_next = pos;
                        mode_next   = key ? jsp_pkg::M_KEY_ESC : jsp_pkg::M_STR_ESC;
                    end
                    else if (c < 8'h20)
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_CTRL_CHAR, pos));
                        err_next = 1'b1;
                    end
                    else if (({1'b0, dlen_reg} + (DW + 1)'(1)) > (DW + 1)'(max_len_reg))
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_STR_LONG, pos + OW'(1)));
                        err_next = 1'b1;
                    end
                    else
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(kind_b, c, 1'b0, 5'd0, 32'd0));
                        ladd = 2'd1;
                    end
                end
                jsp_pkg::M_STR_ESC, jsp_pkg::M_KEY_ESC:
                begin
                    mode_next = key ? jsp_pkg::M_KEY : jsp_pkg::M_STR;
                    ladd      = 2'd1;
                    case (c)
                        8'h22, 8'h5C, 8'h2F:
                            add_res(res_q, res_n, jsp_pkg::mk_res(kind_b, c, 1'b0, 5'd0, 32'd0));
                        8'h62:
                            add_res(res_q, res_n, jsp_pkg::mk_res(kind_b, 8'h08, 1'b0, 5'd0,
                                    32'd0));
                        8'h66:
                            add_res(res_q, res_n, jsp_pkg::mk_res(kind_b, 8'h0C, 1'b0, 5'd0,
                                    32'd0));
                        8'h6E:
                            add_res(res_q, res_n, jsp_pkg::mk_res(kind_b, 8'h0A, 1'b0, 5'd0,
                                    32'd0));
                        8'h72:
                            add_res(res_q, res_n, jsp_pkg::mk_res(kind_b, 8'h0D, 1'b0, 5'd0,
                                    32'd0));
                        8'h74:
                            add_res(res_q, res_n, jsp_pkg::mk_res(kind_b, 8'h09, 1'b0, 5'd0,
                                    32'd0));
                        8'h75:
                        begin
                            uacc_next = 16'd0;
                            hcnt_next = 3'd0;
                            mode_next = key ? jsp_pkg::M_KEY_HEX : jsp_pkg::M_STR_HEX;
                            ladd      = 2'd0;
                        end
                        default:
                        begin
                            add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                    1'b0, jsp_pkg::ERR_BAD_ESC, tstart_reg));
                            err_next  = 1'b1;
                            mode_next = mode_reg;
                            ladd      = 2'd0;
                        end
                    endcase
                end
                jsp_pkg::M_STR_HEX, jsp_pkg::M_KEY_HEX:
                begin
                    hv       = jsp_pkg::hex_val(c);
                    bad      = hcnt_reg[2] | hv[4];
                    hcnt_inc = {1'b0, hcnt_reg[1:0]} + 3'd1;
                    if (!hv[4]) uacc_next = {uacc_reg[11:0], hv[3:0]};
                    if (hcnt_inc < 3'd4)
                    begin
                        hcnt_next = {bad, hcnt_inc[1:0]};
                    end
                    else
                    begin
                        hcnt_next = 3'd0;
                        if (bad)
                        begin
                            add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                    1'b0, jsp_pkg::ERR_BAD_UNI, tstart_reg));
                            err_next = 1'b1;
                        end
                        else
                        begin
                            if (uacc_next < 16'h0080)
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(kind_b, uacc_next[7:0],
                                        1'b0, 5'd0, 32'd0));
                                ladd = 2'd1;
                            end
                            else if (uacc_next < 16'h0800)
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(kind_b,
                                        {3'b110, uacc_next[10:6]}, 1'b0, 5'd0, 32'd0));
                                add_res(res_q, res_n, jsp_pkg::mk_res(kind_b,
                                        {2'b10, uacc_next[5:0]}, 1'b0, 5'd0, 32'd0));
                                ladd = 2'd2;
                            end
                            else
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(kind_b,
                                        {4'b1110, uacc_next[15:12]}, 1'b0, 5'd0, 32'd0));
                                add_res(res_q, res_n, jsp_pkg::mk_res(kind_b,
                                        {2'b10, uacc_next[11:6]}, 1'b0, 5'd0, 32'd0));
                                add_res(res_q, res_n, jsp_pkg::mk_res(kind_b,
                                        {2'b10, uacc_next[5:0]}, 1'b0, 5'd0, 32'd0));
                                ladd = 2'd3;
                            end
                            mode_next = key ? jsp_pkg::M_KEY : jsp_pkg::M_STR;
                        end
                    end
                end
                jsp_pkg::M_LIT:
                begin
                    lidx  = lit_reg[2:0];
                    lkind = (lit_reg[4:3] == 2'd3) ? 2'd0 : lit_reg[4:3];
                    if (lidx >= jsp_pkg::lit_len(lkind) || c != jsp_pkg::lit_char(lkind, lidx))
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_LITERAL, tstart_reg));
                        err_next = 1'b1;
                    end
                    else if (lidx + 3'd1 == jsp_pkg::lit_len(lkind))
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NULL + 4'(lkind),
                                8'd0, 1'b0, 5'd0, 32'd0));
                        mode_next = jsp_pkg::M_AFTER;
                    end
                    else
                    begin
                        lit_next = {lkind, lidx + 3'd1};
                    end
                end
                jsp_pkg::M_NUM:
                begin
                    case (nphase_reg)
                        3'd0:
                        begin
                            if (jsp_pkg::is_digit(c))
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                                nphase_next = (c == 8'h30) ? 3'd1 : 3'd2;
                            end
                            else
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                        1'b0, jsp_pkg::ERR_NUMBER, pos));
                                err_next = 1'b1;
                            end
                        end
                        3'd1, 3'd2:
                        begin
                            if (jsp_pkg::is_digit(c) && nphase_reg == 3'd2)
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                            end
                            else if (c == 8'h2E)
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                                fseen_next  = 1'b1;
                                nphase_next = 3'd3;
                            end
                            else if (c == 8'h65 || c == 8'h45)
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                                fseen_next  = 1'b1;
                                nphase_next = 3'd5;
                            end
                            else
                            begin
                                do_after = 1'b1;
                            end
                        end
                        3'd3:
                        begin
                            if (jsp_pkg::is_digit(c))
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                                nphase_next = 3'd4;
                            end
                            else
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                        1'b0, jsp_pkg::ERR_FRACTION, pos));
                                err_next = 1'b1;
                            end
                        end
                        3'd4:
                        begin
                            if (jsp_pkg::is_digit(c))
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                            end
                            else if (c == 8'h65 || c == 8'h45)
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                                nphase_next = 3'd5;
                            end
                            else
                            begin
                                do_after = 1'b1;
                            end
                        end
                        3'd5, 3'd6:
                        begin
                            if ((c == 8'h2B || c == 8'h2D) && nphase_reg == 3'd5)
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                                nphase_next = 3'd6;
                            end
                            else if (jsp_pkg::is_digit(c))
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                                nphase_next = 3'd7;
                            end
                            else
                            begin
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                        1'b0, jsp_pkg::ERR_EXPONENT, pos));
                                err_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (jsp_pkg::is_digit(c))
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c,
                                        1'b0, 5'd0, 32'd0));
                            else
                                do_after = 1'b1;
                        end
                    endcase
                    if (do_after)
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_END, 8'd0,
                                fseen_reg, 5'd0, 32'd0));
                        mode_next = jsp_pkg::M_AFTER;
                    end
                end
                default:
                begin
                    if (!jsp_pkg::is_ws(c)) do_start = 1'b1;
                end
            endcase

            if (ladd != 2'd0)
            begin
                lsum = {1'b0, dlen_reg} + (DW + 1)'(ladd);
                dlen_next = lsum[DW] ? '1 : lsum[DW-1:0];
            end

            if (do_start)
            begin
                if (c == 8'h7B || c == 8'h5B)
                begin
                    if (level_reg >= NW'(jsp_pkg::MAX_NEST))
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_DEPTH, pos));
                        err_next = 1'b1;
                    end
                    else
                    begin
                        push_en    = 1'b1;
                        push_obj   = (c == 8'h7B);
                        top_next   = push_obj;
                        level_next = level_reg + NW'(1);
                        add_res(res_q, res_n, jsp_pkg::mk_res(push_obj ? jsp_pkg::EV_OBJ_BEGIN :
                                jsp_pkg::EV_ARR_BEGIN, 8'd0, 1'b0, 5'd0, 32'd0));
                        mode_next = push_obj ? jsp_pkg::M_OBJ_FIRST : jsp_pkg::M_ARR_FIRST;
                    end
                end
                else if (c == 8'h22)
                begin
                    dlen_next = '0;
                    mode_next = jsp_pkg::M_STR;
                end
                else if (c == 8'h6E || c == 8'h74 || c == 8'h66)
                begin
                    tstart_next = pos;
                    lit_next    = {(c == 8'h6E) ? 2'd0 : ((c == 8'h74) ? 2'd1 : 2'd2), 3'd1};
                    mode_next   = jsp_pkg::M_LIT;
                end
                else if (c == 8'h2D || jsp_pkg::is_digit(c))
                begin
                    tstart_next = pos;
                    fseen_next  = 1'b0;
                    add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_BYTE, c, 1'b0, 5'd0,
                            32'd0));
                    nphase_next = (c == 8'h2D) ? 3'd0 : ((c == 8'h30) ? 3'd1 : 3'd2);
                    mode_next   = jsp_pkg::M_NUM;
                end
                else
                begin
                    add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                            jsp_pkg::ERR_UNEXPECTED, pos));
                    err_next = 1'b1;
                end
            end

            if (do_after && !jsp_pkg::is_ws(c))
            begin
                obj = top_reg;
                if (level_reg == '0)
                begin
                    add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                            jsp_pkg::ERR_TRAILING, pos));
                    err_next = 1'b1;
                end
                else if (c == 8'h2C)
                begin
                    if (obj)
                        mode_next = jsp_pkg::M_KEY_EXPECT;
                    else if (level_reg > NW'(max_depth_reg))
                    begin
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_DEPTH, pos + OW'(1)));
                        err_next = 1'b1;
                    end
                    else
                        mode_next = jsp_pkg::M_VALUE;
                end
                else if (c == (obj ? 8'h7D : 8'h5D))
                begin
                    level_next = level_reg - NW'(1);
                    top_next   = second_reg;
                    add_res(res_q, res_n, jsp_pkg::mk_res(obj ? jsp_pkg::EV_OBJ_END :
                            jsp_pkg::EV_ARR_END, 8'd0, 1'b0, 5'd0, 32'd0));
                end
                else
                begin
                    add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                            jsp_pkg::ERR_EXP_COMMA, pos));
                    err_next = 1'b1;
                end
            end
        end

        if (byte_valid) boff_next = boff_reg + OW'(1);

        if (end_of_text)
        begin
            pos = boff_next;
            if (!err_next)
            begin
                case (mode_next)
                    jsp_pkg::M_ARR_FIRST:
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                (level_next > NW'(max_depth_reg)) ? jsp_pkg::ERR_DEPTH :
                                jsp_pkg::ERR_END_INPUT, pos));
                    jsp_pkg::M_OBJ_FIRST, jsp_pkg::M_KEY_EXPECT:
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_EXP_STRING, pos));
                    jsp_pkg::M_COLON:
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_EXP_COLON, pos));
                    jsp_pkg::M_STR, jsp_pkg::M_KEY:
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_UNTERM_STR, pos));
                    jsp_pkg::M_STR_ESC, jsp_pkg::M_KEY_ESC:
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_TRUNC_ESC, tstart_next));
                    jsp_pkg::M_STR_HEX, jsp_pkg::M_KEY_HEX:
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_TRUNC_UNI, tstart_next));
                    jsp_pkg::M_LIT:
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_LITERAL, tstart_next));
                    jsp_pkg::M_NUM, jsp_pkg::M_AFTER:
                    begin
                        if (mode_next == jsp_pkg::M_NUM && nphase_next == 3'd0)
                            add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                    1'b0, jsp_pkg::ERR_TRUNC_NUM, pos));
                        else if (mode_next == jsp_pkg::M_NUM && nphase_next == 3'd3)
                            add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                    1'b0, jsp_pkg::ERR_FRACTION, pos));
                        else if (mode_next == jsp_pkg::M_NUM &&
                                 (nphase_next == 3'd5 || nphase_next == 3'd6))
                            add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                    1'b0, jsp_pkg::ERR_EXPONENT, pos));
                        else
                        begin
                            if (mode_next == jsp_pkg::M_NUM)
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_NUM_END,
                                        8'd0, fseen_next, 5'd0, 32'd0));
                            if (level_next == '0)
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_DONE, 8'd0,
                                        1'b0, 5'd0, 32'd0));
                            else
                                add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0,
                                        1'b0, top_next ? jsp_pkg::ERR_UNTERM_OBJ :
                                        jsp_pkg::ERR_UNTERM_ARR, pos));
                        end
                    end
                    default:
                        add_res(res_q, res_n, jsp_pkg::mk_res(jsp_pkg::EV_ERROR, 8'd0, 1'b0,
                                jsp_pkg::ERR_END_INPUT, pos));
                endcase
            end
            mode_next   = jsp_pkg::M_ROOT;
            level_next  = '0;
            dlen_next   = '0;
            uacc_next   = '0;
            hcnt_next   = '0;
            lit_next    = '0;
            nphase_next = '0;
            fseen_next  = 1'b0;
            boff_next   = '0;
            tstart_next = '0;
            err_next    = 1'b0;
            top_next    = 1'b0;
        end

        if (res_n != 3'd0) res_q[res_n[1:0] - 2'd1].last = 1'b1;
    end

    assign level_d = in_accept ? level_next : level_reg;
    assign rd_addr = AW'(level_d - NW'(2));

    always_ff @(posedge clk)
    begin
        if (in_accept && push_en) stack_mem[level_reg[AW-1:0]] <= push_obj;
        second_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= jsp_pkg::MAX_DEPTH_RESET;
            max_len_reg   <= jsp_pkg::MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jsp_pkg::CFG_MAX_DEPTH:  max_depth_reg <= cfg_data[5:0];
                jsp_pkg::CFG_MAX_LENGTH: max_len_reg   <= cfg_data;
                default:                 max_len_reg   <= max_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= jsp_pkg::M_ROOT;
            level_reg  <= '0;
            dlen_reg   <= '0;
            uacc_reg   <= '0;
            hcnt_reg   <= '0;
            lit_reg    <= '0;
            nphase_reg <= '0;
            fseen_reg  <= 1'b0;
            boff_reg   <= '0;
            tstart_reg <= '0;
            err_reg    <= 1'b0;
            top_reg    <= 1'b0;
        end
        else if (in_accept)
        begin
            mode_reg   <= mode_next;
            level_reg  <= level_next;
            dlen_reg   <= dlen_next;
            uacc_reg   <= uacc_next;
            hcnt_reg   <= hcnt_next;
            lit_reg    <= lit_next;
            nphase_reg <= nphase_next;
            fseen_reg  <= fseen_next;
            boff_reg   <= boff_next;
            tstart_reg <= tstart_next;
            err_reg    <= err_next;
            top_reg    <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < jsp_pkg::MAX_RES; i++)
            begin
                if (3'(i) < res_n) queue_reg[wptr_reg + jsp_pkg::QPTR_W'(i)] <= res_q[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (in_accept) wptr_reg <= wptr_reg + jsp_pkg::QPTR_W'(res_n);
            if (out_accept) rptr_reg <= rptr_reg + jsp_pkg::QPTR_W'(1);
            cnt_reg <= cnt_reg + (in_accept ? jsp_pkg::QCNT_W'(res_n) : '0)
                       - (out_accept ? jsp_pkg::QCNT_W'(1) : '0);
        end
    end

    assign out_valid       = cnt_reg != '0;
    assign event_kind      = queue_reg[rptr_reg].kind;
    assign payload_byte    = queue_reg[rptr_reg].payload;
    assign number_is_float = queue_reg[rptr_reg].flt;
    assign error_code      = queue_reg[rptr_reg].code;
    assign error_offset    = queue_reg[rptr_reg].off;
    assign last_of_run     = queue_reg[rptr_reg].last;

    `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, cnt_reg <= jsp_pkg::QCNT_W'(jsp_pkg::QDEPTH))
    `ASSERT_ALWAYS(a_nest_bound, clk, rst_n, level_reg <= NW'(jsp_pkg::MAX_NEST))
    `ASSERT_IMPLIES(a_err_holds, clk, rst_n, err_reg && !(in_accept && end_of_text), err_reg)
    `ASSERT_IMPLIES(a_end_clears, clk, rst_n, in_accept && end_of_text,
                    level_reg == '0 && !err_reg && boff_reg == '0)

endmodule

[dv/tb_json_stream_parser.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// JSON stream parser testbench
// Sends directed and random JSON documents, some of them corrupted, one byte
// per transaction, under several depth and length limits. An internal parser
// model predicts every event, and each event the block emits is compared
// field by field. Both channels idle at random, and one long output stall
// fills the event queue.
//------------------------------------------------------------------------------
class jsp_scoreboard;
    jsp_pkg::res_t event_q[$];
    jsp_pkg::res_t step_events[$];
    int unsigned   errors;

    logic [5:0]       depth_limit;
    logic [23:0]      length_limit;
    jsp_pkg::mode_t   mode;
    bit               kinds[jsp_pkg::MAX_NEST];
    int unsigned      nest;
    longint unsigned  dlen;
    logic [15:0]      uacc;
    logic [2:0]       hexcnt;
    logic [4:0]       litprog;
    logic [2:0]       nphase;
    bit               flt_seen;
    logic [31:0]      boff;
    logic [31:0]      tstart;
    bit               latched;

    function new();
        errors = 0;
        depth_limit = 6'd63;
        length_limit = 24'd1048576;
        new_document();
    endfunction

    function void new_document();
        mode = jsp_pkg::M_ROOT;
        foreach (kinds[i]) kinds[i] = 1'b0;
        nest = 0;
        dlen = 0;
        uacc = '0;
        hexcnt = '0;
        litprog = '0;
        nphase = '0;
        flt_seen = 1'b0;
        boff = '0;
        tstart = '0;
        latched = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [23:0] data);
        if (idx == jsp_pkg::CFG_MAX_DEPTH) depth_limit = data[5:0];
        else length_limit = data;
    endfunction

    function void add_event(logic [3:0] kind, logic [7:0] pay, logic flt,
                            logic [4:0] code, logic [31:0] off);
        jsp_pkg::res_t r;
        r.kind = kind;
        r.payload = pay;
        r.flt = flt;
        r.code = code;
        r.off = off;
        r.last = 1'b0;
        if (step_events.size() < jsp_pkg::MAX_RES) step_events.push_back(r);
    endfunction

    function void fail_at(logic [4:0] code, logic [31:0] off);
        add_event(jsp_pkg::EV_ERROR, 8'd0, 1'b0, code, off);
        latched = 1'b1;
    endfunction

    function bit top_obj();
        if (nest == 0 || nest > jsp_pkg::MAX_NEST) return 1'b0;
        return kinds[nest-1];
    endfunction

    function bit depth_fine(logic [31:0] off);
        if (nest > depth_limit) begin
            fail_at(jsp_pkg::ERR_DEPTH, off);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function void grow_len(int n);
        dlen = dlen + n;
        if (dlen > 64'h1FF_FFFF) dlen = 64'h1FF_FFFF;
    endfunction

    function bit ws(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function void open_value(logic [7:0] c, logic [31:0] pos);
        bit obj;
        if (c == "{" || c == "[") begin
            obj = (c == "{");
            if (nest >= jsp_pkg::MAX_NEST) begin
                fail_at(jsp_pkg::ERR_DEPTH, pos);
                return;
            end
            kinds[nest] = obj;
            nest++;
            add_event(obj ? jsp_pkg::EV_OBJ_BEGIN : jsp_pkg::EV_ARR_BEGIN, 0, 0, 0, 0);
            mode = obj ? jsp_pkg::M_OBJ_FIRST : jsp_pkg::M_ARR_FIRST;
        end else if (c == "\"") begin
            dlen = 0;
            mode = jsp_pkg::M_STR;
        end else if (c == "n" || c == "t" || c == "f") begin
            tstart = pos;
            litprog = {(c == "n") ? 2'd0 : (c == "t") ? 2'd1 : 2'd2, 3'd1};
            mode = jsp_pkg::M_LIT;
        end else if (c == "-" || dig(c)) begin
            tstart = pos;
            flt_seen = 1'b0;
            add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
            nphase = (c == "-") ? 3'd0 : (c == "0") ? 3'd1 : 3'd2;
            mode = jsp_pkg::M_NUM;
        end else begin
            fail_at(jsp_pkg::ERR_UNEXPECTED, pos);
        end
    endfunction

    function void after_value(logic [7:0] c, logic [31:0] pos);
        bit obj;
        if (ws(c)) return;
        if (nest == 0) begin
            fail_at(jsp_pkg::ERR_TRAILING, pos);
            return;
        end
        obj = top_obj();
        if (c == ",") begin
            if (obj) mode = jsp_pkg::M_KEY_EXPECT;
            else if (depth_fine(pos + 1)) mode = jsp_pkg::M_VALUE;
        end else if (c == (obj ? 8'h7D : 8'h5D)) begin
            nest--;
            add_event(obj ? jsp_pkg::EV_OBJ_END : jsp_pkg::EV_ARR_END, 0, 0, 0, 0);
        end else begin
            fail_at(jsp_pkg::ERR_EXP_COMMA, pos);
        end
    endfunction

    function void literal_step(logic [7:0] c);
        string words[3];
        logic [2:0] idx;
        logic [1:0] kind;
        int wlen;
        words[0] = "null";
        words[1] = "true";
        words[2] = "false";
        idx = litprog[2:0];
        kind = litprog[4:3];
        if (kind > 2) kind = 0;
        wlen = words[kind].len();
        if (idx >= wlen || c != words[kind][idx]) begin
            fail_at(jsp_pkg::ERR_LITERAL, tstart);
            return;
        end
        idx++;
        if (idx == wlen) begin
            add_event(jsp_pkg::EV_NULL + kind, 0, 0, 0, 0);
            mode = jsp_pkg::M_AFTER;
        end else begin
            litprog = {kind, idx};
        end
    endfunction

    function void number_step(logic [7:0] c, logic [31:0] pos);
        bit d;
        bit e;
        d = dig(c);
        e = (c == "e" || c == "E");
        case (nphase)
            3'd0:
            begin
                if (d) begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    nphase = (c == "0") ? 3'd1 : 3'd2;
                end else fail_at(jsp_pkg::ERR_NUMBER, pos);
                return;
            end
            3'd1, 3'd2:
            begin
                if (d && nphase == 3'd2) begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    return;
                end
                if (c == ".") begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    flt_seen = 1'b1;
                    nphase = 3'd3;
                    return;
                end
                if (e) begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    flt_seen = 1'b1;
                    nphase = 3'd5;
                    return;
                end
            end
            3'd3:
            begin
                if (d) begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    nphase = 3'd4;
                end else fail_at(jsp_pkg::ERR_FRACTION, pos);
                return;
            end
            3'd4:
            begin
                if (d || e) begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    if (e) nphase = 3'd5;
                    return;
                end
            end
            3'd5:
            begin
                if (c == "+" || c == "-") begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    nphase = 3'd6;
                end else if (d) begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    nphase = 3'd7;
                end else fail_at(jsp_pkg::ERR_EXPONENT, pos);
                return;
            end
            3'd6:
            begin
                if (d) begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    nphase = 3'd7;
                end else fail_at(jsp_pkg::ERR_EXPONENT, pos);
                return;
            end
            default:
            begin
                if (d) begin
                    add_event(jsp_pkg::EV_NUM_BYTE, c, 0, 0, 0);
                    return;
                end
            end
        endcase
        add_event(jsp_pkg::EV_NUM_END, 0, flt_seen, 0, 0);
        mode = jsp_pkg::M_AFTER;
        after_value(c, pos);
    endfunction

    function void text_step(logic [7:0] c, logic [31:0] pos);
        bit key;
        int sub;
        logic [3:0] kind;
        logic [7:0] d;
        logic [4:0] hv;
        bit bad;
        logic [2:0] cnt;
        logic [15:0] u;
        key = (mode inside {jsp_pkg::M_KEY, jsp_pkg::M_KEY_ESC, jsp_pkg::M_KEY_HEX});
        sub = (mode inside {jsp_pkg::M_STR, jsp_pkg::M_KEY}) ? 0 :
              (mode inside {jsp_pkg::M_STR_ESC, jsp_pkg::M_KEY_ESC}) ? 1 : 2;
        kind = key ? jsp_pkg::EV_KEY_BYTE : jsp_pkg::EV_STR_BYTE;
        if (sub == 0) begin
            if (c == "\"") begin
                if (dlen > length_limit) begin
                    fail_at(jsp_pkg::ERR_STR_LONG, pos + 1);
                    return;
                end
                add_event(kind + 1, 0, 0, 0, 0);
                mode = key ? jsp_pkg::M_COLON : jsp_pkg::M_AFTER;
            end else if (c == "\\") begin
                tstart = pos;
                mode = key ? jsp_pkg::M_KEY_ESC : jsp_pkg::M_STR_ESC;
            end else if (c < 8'h20) begin
                fail_at(jsp_pkg::ERR_CTRL_CHAR, pos);
            end else if (dlen + 1 > length_limit) begin
                fail_at(jsp_pkg::ERR_STR_LONG, pos + 1);
            end else begin
                add_event(kind, c, 0, 0, 0);
                grow_len(1);
            end
        end else if (sub == 1) begin
            case (c)
                "\"": d = 8'h22;
                "\\": d = 8'h5C;
                "/":  d = 8'h2F;
                "b":  d = 8'h08;
                "f":  d = 8'h0C;
                "n":  d = 8'h0A;
                "r":  d = 8'h0D;
                "t":  d = 8'h09;
                "u":
                begin
                    uacc = '0;
                    hexcnt = '0;
                    mode = key ? jsp_pkg::M_KEY_HEX : jsp_pkg::M_STR_HEX;
                    return;
                end
                default:
                begin
                    fail_at(jsp_pkg::ERR_BAD_ESC, tstart);
                    return;
                end
            endcase
            add_event(kind, d, 0, 0, 0);
            grow_len(1);
            mode = key ? jsp_pkg::M_KEY : jsp_pkg::M_STR;
        end else begin
            if (dig(c)) hv = c - "0";
            else if (c >= "a" && c <= "f") hv = c - "a" + 10;
            else if (c >= "A" && c <= "F") hv = c - "A" + 10;
            else hv = 5'd16;
            bad = hexcnt[2];
            cnt = {1'b0, hexcnt[1:0]} + 3'd1;
            if (hv > 15) bad = 1'b1;
            else uacc = {uacc[11:0], hv[3:0]};
            if (cnt < 4) begin
                hexcnt = {bad, cnt[1:0]};
                return;
            end
            hexcnt = '0;
            if (bad) begin
                fail_at(jsp_pkg::ERR_BAD_UNI, tstart);
                return;
            end
            u = uacc;
            if (u < 16'h80) begin
                add_event(kind, u[7:0], 0, 0, 0);
                grow_len(1);
            end else if (u < 16'h800) begin
                add_event(kind, 8'hC0 | u[10:6], 0, 0, 0);
                add_event(kind, 8'h80 | u[5:0], 0, 0, 0);
                grow_len(2);
            end else begin
                add_event(kind, 8'hE0 | u[15:12], 0, 0, 0);
                add_event(kind, 8'h80 | u[11:6], 0, 0, 0);
                add_event(kind, 8'h80 | u[5:0], 0, 0, 0);
                grow_len(3);
            end
            mode = key ? jsp_pkg::M_KEY : jsp_pkg::M_STR;
        end
    endfunction

    function void byte_step(logic [7:0] c, logic [31:0] pos);
        case (mode)
            jsp_pkg::M_ARR_FIRST:
            begin
                if (ws(c)) return;
                if (c == "]") begin
                    nest--;
                    add_event(jsp_pkg::EV_ARR_END, 0, 0, 0, 0);
                    mode = jsp_pkg::M_AFTER;
                    return;
                end
                if (depth_fine(pos)) open_value(c, pos);
            end
            jsp_pkg::M_OBJ_FIRST, jsp_pkg::M_KEY_EXPECT:
            begin
                if (ws(c)) return;
                if (c == "}" && mode == jsp_pkg::M_OBJ_FIRST) begin
                    nest--;
                    add_event(jsp_pkg::EV_OBJ_END, 0, 0, 0, 0);
                    mode = jsp_pkg::M_AFTER;
                end else if (c == "\"") begin
                    dlen = 0;
                    mode = jsp_pkg::M_KEY;
                end else fail_at(jsp_pkg::ERR_EXP_STRING, pos);
            end
            jsp_pkg::M_COLON:
            begin
                if (ws(c)) return;
                if (c == ":") begin
                    if (depth_fine(pos + 1)) mode = jsp_pkg::M_VALUE;
                end else fail_at(jsp_pkg::ERR_EXP_COLON, pos);
            end
            jsp_pkg::M_AFTER: after_value(c, pos);
            jsp_pkg::M_STR, jsp_pkg::M_STR_ESC, jsp_pkg::M_STR_HEX,
            jsp_pkg::M_KEY, jsp_pkg::M_KEY_ESC, jsp_pkg::M_KEY_HEX: text_step(c, pos);
            jsp_pkg::M_LIT: literal_step(c);
            jsp_pkg::M_NUM: number_step(c, pos);
            default:
            begin
                if (!ws(c)) open_value(c, pos);
            end
        endcase
    endfunction

    function void closing_after(logic [31:0] pos);
        if (nest == 0) add_event(jsp_pkg::EV_DONE, 0, 0, 0, 0);
        else fail_at(top_obj() ? jsp_pkg::ERR_UNTERM_OBJ : jsp_pkg::ERR_UNTERM_ARR, pos);
    endfunction

    function void end_step(logic [31:0] pos);
        case (mode)
            jsp_pkg::M_ARR_FIRST:
            begin
                if (depth_fine(pos)) fail_at(jsp_pkg::ERR_END_INPUT, pos);
            end
            jsp_pkg::M_OBJ_FIRST, jsp_pkg::M_KEY_EXPECT: fail_at(jsp_pkg::ERR_EXP_STRING, pos);
            jsp_pkg::M_COLON: fail_at(jsp_pkg::ERR_EXP_COLON, pos);
            jsp_pkg::M_STR, jsp_pkg::M_KEY: fail_at(jsp_pkg::ERR_UNTERM_STR, pos);
            jsp_pkg::M_STR_ESC, jsp_pkg::M_KEY_ESC: fail_at(jsp_pkg::ERR_TRUNC_ESC, tstart);
            jsp_pkg::M_STR_HEX, jsp_pkg::M_KEY_HEX: fail_at(jsp_pkg::ERR_TRUNC_UNI, tstart);
            jsp_pkg::M_LIT: fail_at(jsp_pkg::ERR_LITERAL, tstart);
            jsp_pkg::M_NUM:
            begin
                if (nphase == 3'd0) fail_at(jsp_pkg::ERR_TRUNC_NUM, pos);
                else if (nphase == 3'd3) fail_at(jsp_pkg::ERR_FRACTION, pos);
                else if (nphase == 3'd5 || nphase == 3'd6) fail_at(jsp_pkg::ERR_EXPONENT, pos);
                else begin
                    add_event(jsp_pkg::EV_NUM_END, 0, flt_seen, 0, 0);
                    mode = jsp_pkg::M_AFTER;
                    closing_after(pos);
                end
            end
            jsp_pkg::M_AFTER: closing_after(pos);
            default: fail_at(jsp_pkg::ERR_END_INPUT, pos);
        endcase
    endfunction

    function void note_input(logic [7:0] c, logic bv, logic eot);
        step_events.delete();
        if (bv) begin
            if (!latched) byte_step(c, boff);
            boff = boff + 1;
        end
        if (eot) begin
            if (!latched) end_step(boff);
            new_document();
        end
        if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
        foreach (step_events[i]) event_q.push_back(step_events[i]);
    endfunction

    function void check_event(jsp_pkg::res_t got);
        jsp_pkg::res_t want;
        if (event_q.size() == 0) begin
            $display("%0t: unexpected event, kind %0d", $time, got.kind);
            errors++;
            return;
        end
        want = event_q.pop_front();
        if (got.kind != want.kind) begin
            $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
        end
        if (got.payload != want.payload) begin
            $display("%0t: payload_byte expected %h actual %h", $time, want.payload, got.payload);
            errors++;
        end
        if (got.flt != want.flt) begin
            $display("%0t: number_is_float expected %0d actual %0d", $time, want.flt, got.flt);
            errors++;
        end
        if (got.code != want.code) begin
            $display("%0t: error_code expected %0d actual %0d", $time, want.code, got.code);
            errors++;
        end
        if (got.off != want.off) begin
            $display("%0t: error_offset expected %0d actual %0d", $time, want.off, got.off);
            errors++;
        end
        if (got.last != want.last) begin
            $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_json_stream_parser;
    import jsp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  text_byte;
    logic        byte_valid;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  event_kind;
    logic [7:0]  payload_byte;
    logic        number_is_float;
    logic [4:0]  error_code;
    logic [31:0] error_offset;
    logic        last_of_run;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [23:0] cfg_data;

    jsp_scoreboard sb = new();
    logic [7:0]    doc_text[$];
    int            bytes_sent;
    int            burst_left;
    int            idle_cycles;

    json_stream_parser DUT (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall) begin
                got.kind = event_kind;
                got.payload = payload_byte;
                got.flt = number_is_float;
                got.code = error_code;
                got.off = error_offset;
                got.last = last_of_run;
                sb.check_event(got);
                idle_cycles <= 0;
            end
            if (in_valid && !in_stall) begin
                sb.note_input(text_byte, byte_valid, end_of_text);
                idle_cycles <= 0;
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                idle_cycles <= 0;
            end
            if (idle_cycles >= 3000) begin
                $display("tb_json_stream_parser: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int mode_sel;
        int span;
        bit held;
        out_stall <= 1'b0;
        held = 1'b0;
        forever
        begin
            if (!held && bytes_sent >= 150) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            mode_sel = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            repeat (span)
            begin
                case (mode_sel)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= ($urandom_range(0, 7) != 0);
                    default: out_stall <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_item(logic [7:0] c, logic bv, logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        text_byte <= c;
        byte_valid <= bv;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (bv) bytes_sent++;
    endtask

    task automatic send_doc(bit split_end);
        for (int i = 0; i < doc_text.size(); i++)
        begin
            if ($urandom_range(0, 29) == 0) send_item($urandom_range(0, 255), 1'b0, 1'b0);
            send_item(doc_text[i], 1'b1, !split_end && i == doc_text.size() - 1);
        end
        if (split_end || doc_text.size() == 0) send_item($urandom_range(0, 255), 1'b0, 1'b1);
        doc_text.delete();
    endtask

    task automatic send_literal_doc(string s);
        for (int i = 0; i < s.len(); i++) doc_text.push_back(s[i]);
        send_doc(1'b0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.event_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_ws();
        string blanks;
        blanks = " \t\n\r";
        while ($urandom_range(0, 3) == 0) doc_text.push_back(blanks[$urandom_range(0, 3)]);
    endfunction

    function automatic void add_hex(logic [15:0] v);
        string hexdig;
        hexdig = "0123456789abcdef";
        doc_text.push_back("\\");
        doc_text.push_back("u");
        for (int i = 3; i >= 0; i--)
        begin
            if ($urandom_range(0, 40) == 0) doc_text.push_back("g");
            else if (v[i*4 +: 4] > 9 && $urandom_range(0, 1))
                doc_text.push_back("A" + v[i*4 +: 4] - 10);
            else doc_text.push_back(hexdig[v[i*4 +: 4]]);
        end
    endfunction

    function automatic void add_string();
        string esc;
        esc = "\"\\/bfnrt";
        doc_text.push_back("\"");
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 9))
                0: doc_text.push_back("\\");
                1:
                begin
                    doc_text.push_back("\\");
                    doc_text.push_back(esc[$urandom_range(0, 7)]);
                end
                2: add_hex($urandom_range(0, 16'h7F));
                3: add_hex($urandom_range(16'h80, 16'h7FF));
                4: add_hex($urandom_range(16'h800, 16'hFFFF));
                5: doc_text.push_back($urandom_range(8'h80, 8'hFF));
                6: doc_text.push_back(($urandom_range(0, 9) == 0) ?
                                      $urandom_range(0, 8'h1F) : $urandom_range(8'h20, 8'h7F));
                default: doc_text.push_back($urandom_range("a", "z"));
            endcase
            if (doc_text[doc_text.size()-1] == "\\" && doc_text[doc_text.size()-2] != "\\")
                doc_text.push_back(esc[$urandom_range(0, 7)]);
        end
        doc_text.push_back("\"");
    endfunction

    function automatic void add_number();
        if ($urandom_range(0, 2) == 0) doc_text.push_back("-");
        if ($urandom_range(0, 3) == 0) doc_text.push_back("0");
        else repeat ($urandom_range(1, 3)) doc_text.push_back($urandom_range("0", "9"));
        if ($urandom_range(0, 2) == 0) begin
            doc_text.push_back(".");
            repeat ($urandom_range(1, 3)) doc_text.push_back($urandom_range("0", "9"));
        end
        if ($urandom_range(0, 3) == 0) begin
            doc_text.push_back($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0: doc_text.push_back("+");
                1: doc_text.push_back("-");
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) doc_text.push_back($urandom_range("0", "9"));
        end
    endfunction

    function automatic void add_value(int lvl);
        string word;
        int n;
        add_ws();
        case ((lvl < 3) ? $urandom_range(0, 5) : $urandom_range(2, 5))
            0, 1:
            begin
                n = $urandom_range(0, 3);
                doc_text.push_back("[");
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0) doc_text.push_back(",");
                    add_value(lvl + 1);
                end
                add_ws();
                doc_text.push_back("]");
            end
            2:
            begin
                n = $urandom_range(0, 3);
                doc_text.push_back("{");
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0) doc_text.push_back(",");
                    add_ws();
                    add_string();
                    add_ws();
                    doc_text.push_back(":");
                    add_value(lvl + 1);
                end
                add_ws();
                doc_text.push_back("}");
            end
            3: add_string();
            4: add_number();
            default:
            begin
                case ($urandom_range(0, 2))
                    0: word = "null";
                    1: word = "true";
                    default: word = "false";
                endcase
                for (int i = 0; i < word.len(); i++) doc_text.push_back(word[i]);
            end
        endcase
        add_ws();
    endfunction

    task automatic random_docs(int budget);
        int start;
        int pos;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            if ($urandom_range(0, 29) == 0) begin
                repeat ($urandom_range(60, 66)) doc_text.push_back("[");
            end else begin
                add_value(0);
            end
            if (doc_text.size() > 0) begin
                pos = $urandom_range(0, doc_text.size() - 1);
                case ($urandom_range(0, 11))
                    0: doc_text[pos] = $urandom_range(0, 255);
                    1: while (doc_text.size() > pos) void'(doc_text.pop_back());
                    2: doc_text.push_back($urandom_range(0, 255));
                    3: doc_text.insert(pos, $urandom_range(0, 255));
                    default: ;
                endcase
            end
            send_doc($urandom_range(0, 4) == 0);
        end
    endtask

    initial
    begin
        logic [5:0]  depth_set[5];
        logic [23:0] length_set[5];
        rst_n = 1'b0;
        in_valid = 1'b0;
        text_byte = '0;
        byte_valid = 1'b0;
        end_of_text = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAX_DEPTH;
        cfg_data = '0;
        bytes_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        depth_set = '{6'd63, 6'd0, 6'd2, 6'd63, 6'd5};
        length_set = '{24'd1048576, 24'd0, 24'd4, 24'hFFFFFF, 24'd2};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_literal_doc("{\"a\\u00e9\\u4e2d\":[-0.5e+3,10E2,true,false,null,\"\\/\\b\\f\\n\\r\\t\\\"\\\\\"]}");
        send_literal_doc("[01]");
        send_literal_doc(" ");
        drain();

        for (int p = 0; p < 5; p++)
        begin
            if (p > 0) begin
                write_reg(CFG_MAX_DEPTH, {18'd0, depth_set[p]});
                write_reg(CFG_MAX_LENGTH, length_set[p]);
            end
            random_docs(70);
            drain();
        end

        if (sb.errors == 0)
            $display("tb_json_stream_parser: clean");
        else
            $display("tb_json_stream_parser: errors");
        $finish;
    end
endmodule
